// ===== sv/scrp_pkg.sv =====
// Shared types, codes and reset values for the short-circuit retry protection block.
`timescale 1ns / 1ps

package scrp_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MS8_W      = 8;
  localparam int unsigned MS16_W     = 16;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_OFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_ON     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RECOVER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_COUNT  = 3'd4;

  // Register reset values
  localparam logic [MS8_W-1:0]   IGNORE_TIME_RST  = 8'd15;
  localparam logic [MS8_W-1:0]   RETRY_OFF_RST    = 8'd4;
  localparam logic [MS8_W-1:0]   RETRY_ON_RST     = 8'd1;
  localparam logic [MS16_W-1:0]  SLOW_RECOVER_RST = 16'd1000;
  localparam logic [COUNT_W-1:0] RETRY_COUNT_RST  = 4'd3;

  // Phase codes as shown on phase_code
  localparam logic [CODE_W-1:0] PHASE_CODE_IDLE    = 3'd0;
  localparam logic [CODE_W-1:0] PHASE_CODE_IGNORE  = 3'd1;
  localparam logic [CODE_W-1:0] PHASE_CODE_OFF     = 3'd2;
  localparam logic [CODE_W-1:0] PHASE_CODE_ON      = 3'd3;
  localparam logic [CODE_W-1:0] PHASE_CODE_LATCHED = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_IGNORE  = 5'b00010,
    PH_OFF     = 5'b00100,
    PH_ON      = 5'b01000,
    PH_LATCHED = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              track_enable;
    logic              short_reported;
    logic [CODE_W-1:0] phase_code;
  } result_t;

endpackage

// ===== sv/short_circuit_retry_protection.sv =====
// Top level of the short-circuit retry protection block: handshake stages around the core.
`timescale 1ns / 1ps

// One sample item (timestamp, short-sense bit) is taken per clock while the input side
// does not stall, and gives exactly one result item. A sample is held in an input
// register, the state machine step runs between that register and the result register,
// and a new sample can follow every cycle unless stalled. The input side stalls only
// while the result register holds an item not yet taken and the input register is full.
// Configuration writes take effect at the next edge.

module short_circuit_retry_protection (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [scrp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scrp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic [scrp_pkg::TIME_W-1:0]          now_ms,
  input  logic                                 short_sensed,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic                                 track_enable,
  output logic                                 short_reported,
  output logic [scrp_pkg::CODE_W-1:0]          phase_code
);

  logic                        stage_vld;
  logic [scrp_pkg::TIME_W-1:0] stage_now;
  logic                        stage_sh;
  logic                        advance;
  scrp_pkg::cfg_wr_t           cfg;
  scrp_pkg::result_t           result_next;
  scrp_pkg::result_t           result;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign advance      = stage_vld && (!result_valid || result_ready);
  assign sample_ready = !stage_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
    end else if (sample_ready) begin
      stage_vld <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      stage_now <= now_ms;
      stage_sh  <= short_sensed;
    end
  end

  scrp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .now         (stage_now),
    .sh          (stage_sh),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign track_enable   = result.track_enable;
  assign short_reported = result.short_reported;
  assign phase_code     = result.phase_code;

endmodule

// ===== sv/scrp_core.sv =====
// Protection state machine, its timing registers and the configuration registers.
`timescale 1ns / 1ps

module scrp_core (
  input  logic                               clk,
  input  logic                               rst,
  input  scrp_pkg::cfg_wr_t                  cfg,
  input  logic                               advance,
  input  logic [scrp_pkg::TIME_W-1:0]        now,
  input  logic                               sh,
  output scrp_pkg::result_t                  result_next
);

  logic [scrp_pkg::MS8_W-1:0]   ignore_time;
  logic [scrp_pkg::MS8_W-1:0]   retry_off;
  logic [scrp_pkg::MS8_W-1:0]   retry_on;
  logic [scrp_pkg::MS16_W-1:0]  slow_recover;
  logic [scrp_pkg::COUNT_W-1:0] retry_count;

  scrp_pkg::phase_t             phase, phase_next;
  logic [scrp_pkg::TIME_W-1:0]  mark_time, mark_time_next;
  logic [scrp_pkg::COUNT_W-1:0] retries_left, retries_left_next;
  logic                         drive_on, drive_on_next;
  logic                         report;
  logic [scrp_pkg::TIME_W-1:0]  elapsed;
  logic [scrp_pkg::COUNT_W-1:0] retries_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_time  <= scrp_pkg::IGNORE_TIME_RST;
      retry_off    <= scrp_pkg::RETRY_OFF_RST;
      retry_on     <= scrp_pkg::RETRY_ON_RST;
      slow_recover <= scrp_pkg::SLOW_RECOVER_RST;
      retry_count  <= scrp_pkg::RETRY_COUNT_RST;
    end else if (cfg.we) begin
      unique case (cfg.index)
        scrp_pkg::REG_IGNORE_TIME:  ignore_time  <= cfg.data[scrp_pkg::MS8_W-1:0];
        scrp_pkg::REG_RETRY_OFF:    retry_off    <= cfg.data[scrp_pkg::MS8_W-1:0];
        scrp_pkg::REG_RETRY_ON:     retry_on     <= cfg.data[scrp_pkg::MS8_W-1:0];
        scrp_pkg::REG_SLOW_RECOVER: slow_recover <= cfg.data[scrp_pkg::MS16_W-1:0];
        scrp_pkg::REG_RETRY_COUNT:  retry_count  <= cfg.data[scrp_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign elapsed = now - mark_time;

  always_comb begin
    phase_next        = phase;
    mark_time_next    = mark_time;
    retries_left_next = retries_left;
    drive_on_next     = drive_on;
    report            = 1'b0;
    retries_dec       = (retries_left != '0) ? retries_left - 1'b1 : retries_left;
    unique case (phase)
      scrp_pkg::PH_IDLE: begin
        if (sh) begin
          phase_next     = scrp_pkg::PH_IGNORE;
          mark_time_next = now;
        end
      end
      scrp_pkg::PH_IGNORE: begin
        if (!sh) begin
          phase_next    = scrp_pkg::PH_IDLE;
          drive_on_next = 1'b1;
        end else if (elapsed > {{(scrp_pkg::TIME_W-scrp_pkg::MS8_W){1'b0}}, ignore_time}) begin
          phase_next        = scrp_pkg::PH_OFF;
          retries_left_next = retry_count;
          drive_on_next     = 1'b0;
          mark_time_next    = now;
        end
      end
      scrp_pkg::PH_OFF: begin
        if (elapsed > {{(scrp_pkg::TIME_W-scrp_pkg::MS8_W){1'b0}}, retry_off}) begin
          phase_next     = scrp_pkg::PH_ON;
          drive_on_next  = 1'b1;
          mark_time_next = now;
        end
      end
      scrp_pkg::PH_ON: begin
        if (elapsed > {{(scrp_pkg::TIME_W-scrp_pkg::MS8_W){1'b0}}, retry_on}) begin
          if (sh) begin
            mark_time_next    = now;
            drive_on_next     = 1'b0;
            retries_left_next = retries_dec;
            // latch once the counter has run out
            if (retries_dec == '0) begin
              phase_next = scrp_pkg::PH_LATCHED;
              report     = 1'b1;
            end else begin
              phase_next = scrp_pkg::PH_OFF;
            end
          end else begin
            phase_next    = scrp_pkg::PH_IDLE;
            drive_on_next = 1'b1;
          end
        end
      end
      scrp_pkg::PH_LATCHED: begin
        if (sh) begin
          mark_time_next = now;
          report         = 1'b1;
        end else if (elapsed > {{(scrp_pkg::TIME_W-scrp_pkg::MS16_W){1'b0}}, slow_recover}) begin
          // output stays off until a later short clears through the ignore phase
          phase_next = scrp_pkg::PH_IDLE;
        end
      end
      default: phase_next = scrp_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= scrp_pkg::PH_IDLE;
      mark_time    <= '0;
      retries_left <= '0;
      drive_on     <= 1'b1;
    end else if (advance) begin
      phase        <= phase_next;
      mark_time    <= mark_time_next;
      retries_left <= retries_left_next;
      drive_on     <= drive_on_next;
    end
  end

  always_comb begin
    result_next.track_enable   = drive_on_next;
    result_next.short_reported = report;
    unique case (phase_next)
      scrp_pkg::PH_IGNORE:  result_next.phase_code = scrp_pkg::PHASE_CODE_IGNORE;
      scrp_pkg::PH_OFF:     result_next.phase_code = scrp_pkg::PHASE_CODE_OFF;
      scrp_pkg::PH_ON:      result_next.phase_code = scrp_pkg::PHASE_CODE_ON;
      scrp_pkg::PH_LATCHED: result_next.phase_code = scrp_pkg::PHASE_CODE_LATCHED;
      default:              result_next.phase_code = scrp_pkg::PHASE_CODE_IDLE;
    endcase
  end

endmodule

// ===== sv/scrp_checker.sv =====
// Port-level checker for the short-circuit retry protection block and its bind.
`timescale 1ns / 1ps

module scrp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          track_enable,
  input logic                          short_reported,
  input logic [scrp_pkg::CODE_W-1:0]   phase_code
);

  // a stalled result item holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(track_enable) && $stable(short_reported) && $stable(phase_code))
    else $error("result item changed while stalled");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> phase_code <= scrp_pkg::PHASE_CODE_LATCHED)
    else $error("phase code out of range");

  a_report_latched: assert property (@(posedge clk) disable iff (rst)
    result_valid && short_reported |-> phase_code == scrp_pkg::PHASE_CODE_LATCHED)
    else $error("short reported outside the latched phase");

  a_off_disabled: assert property (@(posedge clk) disable iff (rst)
    result_valid && (phase_code == scrp_pkg::PHASE_CODE_OFF ||
                     phase_code == scrp_pkg::PHASE_CODE_LATCHED) |-> !track_enable)
    else $error("track enabled while off or latched");

  a_on_enabled: assert property (@(posedge clk) disable iff (rst)
    result_valid && phase_code == scrp_pkg::PHASE_CODE_ON |-> track_enable)
    else $error("track disabled during retry on time");

endmodule

bind short_circuit_retry_protection scrp_checker u_scrp_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .track_enable   (track_enable),
  .short_reported (short_reported),
  .phase_code     (phase_code)
);
